// File: hdl/tcw_pkg.sv
package tcw_pkg;

  // Fixed field widths of the console interface.
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int INDEX_W  = 11;
  localparam int CURSOR_W = 11;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Cursor moves.
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_HOME,
    CUR_LEFT,
    CUR_RIGHT,
    CUR_DOWN
  } cur_op_e;

  // Cell memory writes.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_CHAR,
    WR_TAB_SPACE,
    WR_COPY,
    WR_BLANK,
    WR_CLEAR
  } wr_op_e;

  // Cell memory reads.
  typedef enum logic [1:0] {
    RD_NONE,
    RD_INDEX,
    RD_SCAN
  } rd_op_e;

  // Scan counter moves.
  typedef enum logic [1:0] {
    SCAN_HOLD,
    SCAN_COPY,
    SCAN_BLANK,
    SCAN_NEXT
  } scan_op_e;

  typedef struct packed {
    logic     capture;
    cur_op_e  cur;
    wr_op_e   wr;
    rd_op_e   rd;
    scan_op_e scan;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic is_cr;
    logic is_lf;
    logic is_bs;
    logic is_tab;
    logic col_zero;
    logic col_at_edge;
    logic row_last;
    logic tab_last;
    logic scan_first;
    logic scan_copy_end;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// File: hdl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/tcw_ctrl.sv
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);

  import tcw_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DECODE = 7'b0000100,
    S_TAB    = 7'b0001000,
    S_COPY   = 7'b0010000,
    S_BLANK  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.cur      = CUR_HOLD;
    cmd_o.wr       = WR_NONE;
    cmd_o.rd       = RD_NONE;
    cmd_o.scan     = SCAN_HOLD;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr = WR_CLEAR;
        if (status_i.scan_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.scan = SCAN_NEXT;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        if (status_i.op_read) begin
          cmd_o.rd = RD_INDEX;
        end else if (status_i.is_cr) begin
          cmd_o.cur = CUR_HOME;
        end else if (status_i.is_lf) begin
          if (status_i.row_last) begin
            cmd_o.scan = SCAN_COPY;
            state_d    = S_COPY;
          end else begin
            cmd_o.cur = CUR_DOWN;
          end
        end else if (status_i.is_bs) begin
          if (!status_i.col_zero) begin
            cmd_o.cur = CUR_LEFT;
          end
        end else if (status_i.is_tab) begin
          if (!status_i.col_at_edge) begin
            state_d = S_TAB;
          end
        end else if (!status_i.col_at_edge) begin
          cmd_o.wr  = WR_CHAR;
          cmd_o.cur = CUR_RIGHT;
        end
      end
      S_TAB: begin
        cmd_o.wr  = WR_TAB_SPACE;
        cmd_o.cur = CUR_RIGHT;
        if (status_i.tab_last) begin
          state_d = S_FINISH;
        end
      end
      S_COPY: begin
        // Read one line ahead while the previous read lands one line up.
        if (!status_i.scan_copy_end) begin
          cmd_o.rd = RD_SCAN;
        end
        if (!status_i.scan_first) begin
          cmd_o.wr = WR_COPY;
        end
        if (status_i.scan_copy_end) begin
          cmd_o.scan = SCAN_BLANK;
          state_d    = S_BLANK;
        end else begin
          cmd_o.scan = SCAN_NEXT;
        end
      end
      S_BLANK: begin
        cmd_o.wr = WR_BLANK;
        if (status_i.scan_last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.scan = SCAN_NEXT;
        end
      end
      S_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  // A tab step is only ever taken left of the right edge.
  a_tab_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAB) |-> !status_i.col_at_edge)
    else $error("tab step at right edge");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  // A word is only captured while the input is open.
  a_capture_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |-> !in_stall_o)
    else $error("word captured while the input stalls");

endmodule

// File: hdl/tcw_datapath.sv
module tcw_datapath #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_write_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data_i,
  input  logic                          operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index_i,
  input  logic                          end_of_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data_o,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position_o,
  output logic                          cursor_update_o,
  input  tcw_pkg::cmd_t                 cmd_i,
  output tcw_pkg::status_t              status_o
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SCAN_W = $clog2(CELLS + 1);
  localparam int POS_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int TAB_W  = $clog2(TAB_WIDTH);

  // Captured item.
  logic                op_q;
  logic [CHAR_W-1:0]   ch_q;
  logic [INDEX_W-1:0]  idx_q;
  logic                eor_q;

  // Console state.
  logic [ROW_W-1:0]    row_q, row_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [TAB_W-1:0]    phase_q, phase_d;
  logic [SCAN_W-1:0]   scan_q, scan_d;
  logic [ATTR_W-1:0]   attr_q;

  // Result register.
  logic                out_valid_q;
  logic [CELL_W-1:0]   cell_q;
  logic [CURSOR_W-1:0] pos_out_q;
  logic                upd_q;

  logic [POS_W-1:0]    pos;
  logic [SCAN_W-1:0]   copy_dst;
  logic                in_range;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  assign pos      = POS_W'(row_q) * POS_W'(COLUMNS) + POS_W'(col_q);
  assign copy_dst = scan_q - SCAN_W'(COLUMNS + 1);
  assign in_range = ({{(32 - INDEX_W){1'b0}}, idx_q} < 32'(CELLS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      ch_q  <= char_code_i;
      idx_q <= cell_index_i;
      eor_q <= end_of_request_i;
    end
  end

  // Cursor, tab phase (column modulo the tab width) and scan counter.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    phase_d = phase_q;
    case (cmd_i.cur)
      CUR_HOME: begin
        col_d   = '0;
        phase_d = '0;
      end
      CUR_LEFT: begin
        col_d   = col_q - COL_W'(1);
        phase_d = (phase_q == '0) ? TAB_W'(TAB_WIDTH - 1) : phase_q - TAB_W'(1);
      end
      CUR_RIGHT: begin
        col_d   = col_q + COL_W'(1);
        phase_d = (phase_q == TAB_W'(TAB_WIDTH - 1)) ? '0 : phase_q + TAB_W'(1);
      end
      CUR_DOWN: begin
        row_d = row_q + ROW_W'(1);
      end
      default: begin
      end
    endcase

    scan_d = scan_q;
    case (cmd_i.scan)
      SCAN_COPY:  scan_d = SCAN_W'(COLUMNS);
      SCAN_BLANK: scan_d = SCAN_W'(CELLS - COLUMNS);
      SCAN_NEXT:  scan_d = scan_q + SCAN_W'(1);
      default:    scan_d = scan_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      phase_q <= '0;
      scan_q  <= '0;
      attr_q  <= ATTR_RESET;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      scan_q  <= scan_d;
      if (cfg_write_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  // Memory port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    case (cmd_i.wr)
      WR_CHAR: begin
        ram_we    = 1'b1;
        ram_waddr = pos[ADDR_W-1:0];
        ram_wdata = {attr_q, ch_q};
      end
      WR_TAB_SPACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos[ADDR_W-1:0];
        ram_wdata = {attr_q, CH_SPACE};
      end
      WR_COPY: begin
        ram_we    = 1'b1;
        ram_waddr = copy_dst[ADDR_W-1:0];
        ram_wdata = ram_rdata;
      end
      WR_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[ADDR_W-1:0];
        ram_wdata = {attr_q, CH_SPACE};
      end
      WR_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[ADDR_W-1:0];
      end
      default: begin
      end
    endcase

    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd_i.rd)
      RD_INDEX: begin
        ram_re    = 1'b1;
        ram_raddr = in_range ? ADDR_W'(idx_q) : '0;
      end
      RD_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_q[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Result register; a read's data is still held by the memory output.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      cell_q    <= (op_q && in_range) ? ram_rdata : '0;
      pos_out_q <= CURSOR_W'(pos);
      upd_q     <= !op_q && eor_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_data_o       = cell_q;
  assign cursor_position_o = pos_out_q;
  assign cursor_update_o   = upd_q;

  always_comb begin
    status_o               = '0;
    status_o.op_read       = op_q;
    status_o.is_cr         = (ch_q == CH_CR);
    status_o.is_lf         = (ch_q == CH_LF);
    status_o.is_bs         = (ch_q == CH_BS);
    status_o.is_tab        = (ch_q == CH_TAB);
    status_o.col_zero      = (col_q == '0);
    status_o.col_at_edge   = (col_q == COL_W'(COLUMNS));
    status_o.row_last      = (row_q == ROW_W'(ROWS - 1));
    status_o.tab_last      = (col_q == COL_W'(COLUMNS - 1)) ||
                             (phase_q == TAB_W'(TAB_WIDTH - 1));
    status_o.scan_first    = (scan_q == SCAN_W'(COLUMNS));
    status_o.scan_copy_end = (scan_q == SCAN_W'(CELLS));
    status_o.scan_last     = (scan_q == SCAN_W'(CELLS - 1));
    status_o.out_busy      = out_valid_q && out_stall_i;
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a waiting word");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_W'(ROWS - 1)) && (col_q <= COL_W'(COLUMNS)))
    else $error("cursor out of screen bounds");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("cell memory read and written at one address");

endmodule

// File: hdl/text_console_char_writer.sv
// Channel   Direction  Handshake               Word
// input     in         in_valid_i / in_stall_o  operation, char_code, cell_index, end_of_request
// result    out        out_valid_o / out_stall_i cell_data, cursor_position, cursor_update
// config    in         cfg_write_i             cfg_data_i (text attribute)
//
// One word at a time: a character, carriage return, line feed without scroll, backspace
// or cell read is captured, decoded and loaded into the output register once no earlier
// result is held by out_stall_i; then the next word is taken. A tab writes a space into
// each padded cell, up to TAB_WIDTH. A scrolling line feed copies each lower line one up
// and blanks the last line. After reset the cell memory is cleared before the first word.
// A result held by out_stall_i waits in an output register while the next word goes in.
module text_console_char_writer #(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TAB_WIDTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_write_i,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          operation_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index_i,
  input  logic                          end_of_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data_o,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position_o,
  output logic                          cursor_update_o
);

  import tcw_pkg::*;

  // The controller sequences each word; the datapath holds the cursor, the
  // attribute register, the scan counter and the cell memory.
  cmd_t    cmd;
  status_t status;

  tcw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_WIDTH(TAB_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_write_i      (cfg_write_i),
    .cfg_data_i       (cfg_data_i),
    .operation_i      (operation_i),
    .char_code_i      (char_code_i),
    .cell_index_i     (cell_index_i),
    .end_of_request_i (end_of_request_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .cell_data_o      (cell_data_o),
    .cursor_position_o(cursor_position_o),
    .cursor_update_o  (cursor_update_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule
